// ===== src/prepaid_activation_lockout_timer_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PREPAID_ACTIVATION_LOCKOUT_TIMER_UNIT_DEFINES_SVH
`define PREPAID_ACTIVATION_LOCKOUT_TIMER_UNIT_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define PALT_ASSERT_NOW(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// Condition holds in the cycle after the trigger.
`define PALT_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== src/palt_pkg.sv =====
package palt_pkg;

   localparam int MAX_FAILS         = 9;
   localparam int LOCK_UNIT_SECONDS = 60;
   localparam int SECONDS_PER_DAY   = 3600 * 24;

   localparam int TIME_W  = 32;
   localparam int VALUE_W = 10;
   localparam int DIVR_W  = 8;
   localparam int FAIL_W  = 4;
   localparam int BLINK_W = 3;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   // widest lock time is 2^MAX_FAILS units
   localparam int LOCK_W = $clog2((2 ** MAX_FAILS) * LOCK_UNIT_SECONDS + 1);
   // value * seconds per day
   localparam int PROD_W = $clog2((2 ** VALUE_W - 1) * SECONDS_PER_DAY + 1);
   localparam int DIV_STEPS = PROD_W;
   localparam int CNT_W = $clog2(DIV_STEPS);

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   localparam logic [VALUE_W-1:0] SYNC_RESET    = VALUE_W'(999);
   localparam logic [VALUE_W-1:0] DISABLE_RESET = VALUE_W'(998);
   localparam logic [DIVR_W-1:0]  DIVIDER_RESET = DIVR_W'(1);

   localparam logic [1:0] REG_SYNC    = 2'd0;
   localparam logic [1:0] REG_DISABLE = 2'd1;
   localparam logic [1:0] REG_DIVIDER = 2'd2;

   localparam logic [BLINK_W-1:0] BLINK_NONE     = 3'd0;
   localparam logic [BLINK_W-1:0] BLINK_CREDIT   = 3'd2;
   localparam logic [BLINK_W-1:0] BLINK_SYNC     = 3'd3;
   localparam logic [BLINK_W-1:0] BLINK_DISABLED = 3'd5;

   typedef enum logic [2:0] {
      OP_QUERY,
      OP_FAIL,
      OP_SYNC,
      OP_DISABLE,
      OP_CREDIT
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_UPDATE,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic load_calc;
      logic div_step;
      logic update;
      logic report;
   } cmd_type;

   typedef struct packed {
      logic is_credit;
      logic out_free;
   } stat_type;

   function automatic logic [LOCK_W-1:0] lock_seconds(input logic [FAIL_W-1:0] fails);
      return LOCK_W'(LOCK_UNIT_SECONDS) << fails;
   endfunction

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
   endfunction

endpackage

// ===== src/palt_ctrl.sv =====
module palt_ctrl import palt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_calc = 1'b1;
            cnt_in        = CNT_W'(DIV_STEPS - 1);
            state_in      = stat.is_credit ? ST_DIV : ST_UPDATE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_REPORT;
         end
         ST_REPORT: begin
            // hold until the output register can take the word
            if (stat.out_free) begin
               cmd.report = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== src/palt_dp.sv =====
module palt_dp import palt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               req_kind,
   input  logic [TIME_W-1:0]  req_now_seconds,
   input  logic               req_token_invalid,
   input  logic [VALUE_W-1:0] req_token_value,
   input  logic               req_count_is_odd,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_active,
   output logic               rsp_entry_allowed,
   output logic [BLINK_W-1:0] rsp_blink_code,
   output logic [TIME_W-1:0]  rsp_credit_end,
   output logic [TIME_W-1:0]  rsp_lock_end,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [DATA_W-1:0]  csr_pwdata,
   output logic [DATA_W-1:0]  csr_prdata
);

   logic               kind_ff, invalid_ff, odd_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [VALUE_W-1:0] value_ff;

   logic [VALUE_W-1:0] sync_ff, disable_ff;
   logic [DIVR_W-1:0]  divider_ff;
   logic               csr_wr;
   logic [DIVR_W-1:0]  divisor;

   op_type             op_dec, op_ff;
   logic [PROD_W-1:0]  quo_ff, quo_in;
   logic [DIVR_W-1:0]  rem_ff, rem_in;
   logic [DIVR_W:0]    trial;

   logic [FAIL_W-1:0]  fail_ff, fail_in;
   logic [TIME_W-1:0]  lock_ff, lock_in, active_ff, active_in, base;
   logic               meter_ff, meter_in;
   logic [BLINK_W-1:0] blink_ff, blink_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_active_ff, rsp_entry_ff;
   logic [BLINK_W-1:0] rsp_blink_ff;
   logic [TIME_W-1:0]  rsp_credit_ff, rsp_lock_ff;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff    <= req_kind;
         now_ff     <= req_now_seconds;
         invalid_ff <= req_token_invalid;
         value_ff   <= req_token_value;
         odd_ff     <= req_count_is_odd;
      end
   end

   // configuration registers
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff    <= SYNC_RESET;
         disable_ff <= DISABLE_RESET;
         divider_ff <= DIVIDER_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_SYNC:    sync_ff    <= csr_pwdata[VALUE_W-1:0];
            REG_DISABLE: disable_ff <= csr_pwdata[VALUE_W-1:0];
            REG_DIVIDER: divider_ff <= csr_pwdata[DIVR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SYNC:    csr_prdata = DATA_W'(sync_ff);
         REG_DISABLE: csr_prdata = DATA_W'(disable_ff);
         REG_DIVIDER: csr_prdata = DATA_W'(divider_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // token classification, sync wins over disable
   always_comb begin
      priority if (!kind_ff)            op_dec = OP_QUERY;
      else if (invalid_ff)              op_dec = OP_FAIL;
      else if (value_ff == sync_ff)     op_dec = OP_SYNC;
      else if (value_ff == disable_ff)  op_dec = OP_DISABLE;
      else                              op_dec = OP_CREDIT;
   end

   assign divisor = (divider_ff == '0) ? DIVR_W'(1) : divider_ff;

   // restoring divider, one quotient bit per step
   assign trial = {rem_ff, quo_ff[PROD_W-1]};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.load_calc) begin
         quo_in = PROD_W'(value_ff) * PROD_W'(SECONDS_PER_DAY);
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = DIVR_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVR_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.load_calc) begin
         op_ff <= op_dec;
      end
   end

   // state update
   assign base = (odd_ff || (active_ff < now_ff)) ? now_ff : active_ff;

   always_comb begin
      fail_in   = fail_ff;
      lock_in   = lock_ff;
      active_in = active_ff;
      meter_in  = meter_ff;
      blink_in  = blink_ff;
      if (cmd.update) begin
         blink_in = BLINK_NONE;
         unique case (op_ff)
            OP_QUERY: ;
            OP_FAIL: begin
               fail_in = (fail_ff < FAIL_W'(MAX_FAILS)) ? fail_ff + 1'b1
                                                         : FAIL_W'(MAX_FAILS);
               lock_in = sat_add(now_ff, TIME_W'(lock_seconds(fail_in)));
            end
            OP_SYNC: begin
               fail_in  = '0;
               blink_in = BLINK_SYNC;
            end
            OP_DISABLE: begin
               fail_in  = '0;
               meter_in = 1'b0;
               blink_in = BLINK_DISABLED;
            end
            OP_CREDIT: begin
               fail_in   = '0;
               meter_in  = 1'b1;
               active_in = sat_add(base, TIME_W'(quo_ff));
               blink_in  = BLINK_CREDIT;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_ff   <= '0;
         lock_ff   <= '0;
         active_ff <= '0;
         meter_ff  <= 1'b1;
      end else begin
         fail_ff   <= fail_in;
         lock_ff   <= lock_in;
         active_ff <= active_in;
         meter_ff  <= meter_in;
      end
   end

   always_ff @(posedge clock) begin
      blink_ff <= blink_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.report) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.report) begin
         rsp_active_ff <= !meter_ff || (active_ff > now_ff);
         rsp_entry_ff  <= !(lock_ff > now_ff);
         rsp_blink_ff  <= blink_ff;
         rsp_credit_ff <= active_ff;
         rsp_lock_ff   <= lock_ff;
      end
   end

   assign stat.is_credit = (op_dec == OP_CREDIT);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_active        = rsp_active_ff;
   assign rsp_entry_allowed = rsp_entry_ff;
   assign rsp_blink_code    = rsp_blink_ff;
   assign rsp_credit_end    = rsp_credit_ff;
   assign rsp_lock_end      = rsp_lock_ff;

endmodule

// ===== src/prepaid_activation_lockout_timer_unit.sv =====
// Prepaid activation and token lockout timer. Each word on req_ carries the current
// time; a token word updates the failure count, the entry lock, the metering state
// and the credit end, a query word only reports, and every word gives one rsp_ word
// with the state after the update. One word is worked at a time. A credit token goes
// through the multiply, 27 steps of the bit-serial credit divider, update and report;
// any other word goes through load, update and report. The next word is accepted
// once the block is back in idle. The output register lets the next word be accepted
// while a result waits to be taken; a result that is still not taken when the next
// one is ready holds the block in its report step. The sync value, disable value and
// credit divider registers sit at byte addresses 0, 4 and 8 of the csr_ port.
module prepaid_activation_lockout_timer_unit import palt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [TIME_W-1:0]  req_now_seconds,
   input  logic               req_token_invalid,
   input  logic [VALUE_W-1:0] req_token_value,
   input  logic               req_count_is_odd,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_active,
   output logic               rsp_entry_allowed,
   output logic [BLINK_W-1:0] rsp_blink_code,
   output logic [TIME_W-1:0]  rsp_credit_end,
   output logic [TIME_W-1:0]  rsp_lock_end,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [DATA_W-1:0]  csr_pwdata,
   output logic [DATA_W-1:0]  csr_prdata,
   output logic               csr_pready
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_pready = 1'b1;

   palt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   palt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_kind),
      .req_now_seconds   (req_now_seconds),
      .req_token_invalid (req_token_invalid),
      .req_token_value   (req_token_value),
      .req_count_is_odd  (req_count_is_odd),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_active        (rsp_active),
      .rsp_entry_allowed (rsp_entry_allowed),
      .rsp_blink_code    (rsp_blink_code),
      .rsp_credit_end    (rsp_credit_end),
      .rsp_lock_end      (rsp_lock_end),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata)
   );

endmodule

// ===== src/palt_checker.sv =====
`include "prepaid_activation_lockout_timer_unit_defines.svh"

module palt_checker import palt_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_active,
   input logic [BLINK_W-1:0] rsp_blink_code,
   input logic [TIME_W-1:0]  rsp_credit_end,
   input logic [TIME_W-1:0]  rsp_lock_end
);

   `PALT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_credit_end) && $stable(rsp_lock_end)
         && $stable(rsp_blink_code),
      "result word changed while stalled")
   `PALT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
      "second word taken while one is in work")
   `PALT_ASSERT_NOW(a_blink_legal, rsp_valid,
      rsp_blink_code == BLINK_NONE || rsp_blink_code == BLINK_CREDIT
         || rsp_blink_code == BLINK_SYNC || rsp_blink_code == BLINK_DISABLED,
      "unknown blink code")
   `PALT_ASSERT_NOW(a_disabled_active, rsp_valid && rsp_blink_code == BLINK_DISABLED,
      rsp_active, "disabled metering reported inactive")

endmodule

bind prepaid_activation_lockout_timer_unit palt_checker u_palt_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import palt_pkg::*;

   localparam logic KIND_QUERY = 1'b0;
   localparam logic KIND_TOKEN = 1'b1;
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 1000;
   localparam int WORDS_PER_PHASE = 190;

   typedef struct packed {
      logic               kind;
      logic [TIME_W-1:0]  now;
      logic               invalid;
      logic [VALUE_W-1:0] value;
      logic               odd;
   } req_word_type;

   typedef struct packed {
      logic               active;
      logic               entry_allowed;
      logic [BLINK_W-1:0] blink;
      logic [TIME_W-1:0]  credit_end;
      logic [TIME_W-1:0]  lock_end;
   } status_word_type;

   // Timer state mirror plus the queue of status words still owed by the block.
   class status_scoreboard_type;
      logic [VALUE_W-1:0] sync_reg;
      logic [VALUE_W-1:0] disable_reg;
      logic [DIVR_W-1:0]  divider_reg;
      logic [FAIL_W-1:0]  fails;
      logic [TIME_W-1:0]  lock_until;
      logic [TIME_W-1:0]  active_until;
      logic               metering_on;
      status_word_type    status_q[$];
      int                 errors;

      function new();
         sync_reg     = SYNC_RESET;
         disable_reg  = DISABLE_RESET;
         divider_reg  = DIVIDER_RESET;
         fails        = '0;
         lock_until   = '0;
         active_until = '0;
         metering_on  = 1'b1;
         errors       = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [DATA_W-1:0] data);
         case (idx)
            REG_SYNC:    sync_reg    = data[VALUE_W-1:0];
            REG_DISABLE: disable_reg = data[VALUE_W-1:0];
            REG_DIVIDER: divider_reg = data[DIVR_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [TIME_W-1:0] clamp_time(longint unsigned sum);
         return (sum > 64'h0000_0000_FFFF_FFFF) ? TIME_MAX : sum[TIME_W-1:0];
      endfunction

      // Advance the timer state by one accepted word and queue the status it reports.
      function void take_token_word(req_word_type w);
         status_word_type s;
         longint unsigned credit_secs;
         logic [TIME_W-1:0] base;
         logic [DIVR_W-1:0] div;
         s.blink = BLINK_NONE;
         if (w.kind == KIND_TOKEN) begin
            if (w.invalid) begin
               if (fails < MAX_FAILS) fails++;
               lock_until = clamp_time(64'(w.now) + (64'(LOCK_UNIT_SECONDS) << fails));
            end else begin
               fails = '0;
               if (w.value == sync_reg) begin
                  s.blink = BLINK_SYNC;
               end else if (w.value == disable_reg) begin
                  metering_on = 1'b0;
                  s.blink = BLINK_DISABLED;
               end else begin
                  div = (divider_reg == '0) ? DIVR_W'(1) : divider_reg;
                  credit_secs = (64'(w.value) * 64'(SECONDS_PER_DAY)) / 64'(div);
                  metering_on = 1'b1;
                  if (w.odd) begin
                     active_until = clamp_time(64'(w.now) + credit_secs);
                  end else begin
                     base = (active_until < w.now) ? w.now : active_until;
                     active_until = clamp_time(64'(base) + credit_secs);
                  end
                  s.blink = BLINK_CREDIT;
               end
            end
         end
         s.active        = !metering_on || (active_until > w.now);
         s.entry_allowed = !(lock_until > w.now);
         s.credit_end    = active_until;
         s.lock_end      = lock_until;
         status_q.push_back(s);
      endfunction

      function void compare_field(string name, logic [TIME_W-1:0] want,
                                  logic [TIME_W-1:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
         end
      endfunction

      function void check_status_word(status_word_type got);
         status_word_type want;
         if (status_q.size() == 0) begin
            errors++;
            $display("%0t: status word with none expected: got %h", $time, got);
            return;
         end
         want = status_q.pop_front();
         compare_field("active", 32'(want.active), 32'(got.active));
         compare_field("entry_allowed", 32'(want.entry_allowed), 32'(got.entry_allowed));
         compare_field("blink_code", 32'(want.blink), 32'(got.blink));
         compare_field("credit_end", want.credit_end, got.credit_end);
         compare_field("lock_end", want.lock_end, got.lock_end);
      endfunction

      function int pending();
         return status_q.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_kind;
   logic [TIME_W-1:0]  req_now_seconds;
   logic               req_token_invalid;
   logic [VALUE_W-1:0] req_token_value;
   logic               req_count_is_odd;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_active;
   logic               rsp_entry_allowed;
   logic [BLINK_W-1:0] rsp_blink_code;
   logic [TIME_W-1:0]  rsp_credit_end;
   logic [TIME_W-1:0]  rsp_lock_end;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [ADDR_W-1:0]  csr_paddr;
   logic [DATA_W-1:0]  csr_pwdata;
   logic [DATA_W-1:0]  csr_prdata;
   logic               csr_pready;

   status_scoreboard_type sb;
   int burst_left;
   int fail_run;
   int idle_cycles;
   logic [TIME_W-1:0] now_cursor;

   prepaid_activation_lockout_timer_unit i_dut (.*);

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic req_word_type mk(logic kind, logic [TIME_W-1:0] now, logic invalid,
                                       logic [VALUE_W-1:0] value, logic odd);
      req_word_type w;
      w.kind    = kind;
      w.now     = now;
      w.invalid = invalid;
      w.value   = value;
      w.odd     = odd;
      return w;
   endfunction

   // Call at a falling edge; returns at a falling edge.
   task automatic send_word(req_word_type w);
      int gap;
      req_valid         <= 1'b1;
      req_kind          <= w.kind;
      req_now_seconds   <= w.now;
      req_token_invalid <= w.invalid;
      req_token_value   <= w.value;
      req_count_is_odd  <= w.odd;
      do @(posedge clock); while (!req_ready);
      sb.take_token_word(w);
      @(negedge clock);
      if (burst_left <= 1) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, data);
   endtask

   // Write all three registers, plus the unused slot when asked, with the block idle.
   task automatic configure(logic [DATA_W-1:0] sync_v, logic [DATA_W-1:0] disable_v,
                            logic [DATA_W-1:0] divider_v, bit poke_unused);
      drain_results();
      repeat (8) @(negedge clock);
      csr_write(REG_SYNC, sync_v);
      csr_write(REG_DISABLE, disable_v);
      csr_write(REG_DIVIDER, divider_v);
      if (poke_unused) csr_write(REG_UNUSED, $urandom);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return VALUE_W'($urandom);
   endfunction

   function automatic req_word_type make_random_word();
      req_word_type w;
      op_type       op;
      int           r;
      r = $urandom_range(0, 9);
      if (r == 0)
         now_cursor = $urandom;
      else if (r == 1)
         now_cursor = TIME_MAX - TIME_W'($urandom_range(0, 100000));
      else
         case ($urandom_range(0, 2))
            0: now_cursor += TIME_W'($urandom_range(0, 120));
            1: now_cursor += TIME_W'($urandom_range(0, 4000));
            default: now_cursor += TIME_W'($urandom_range(0, 400000));
         endcase
      if (fail_run > 0) begin
         fail_run--;
         op = OP_FAIL;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 20)      op = OP_QUERY;
         else if (r < 45) op = OP_FAIL;
         else if (r < 52) op = OP_SYNC;
         else if (r < 57) op = OP_DISABLE;
         else             op = OP_CREDIT;
         // start a run of rejected tokens to push the count into saturation
         if (op == OP_FAIL && $urandom_range(0, 9) < 3) fail_run = $urandom_range(2, 12);
      end
      w = mk(KIND_TOKEN, now_cursor, 1'b0, pick_value(), 1'($urandom));
      case (op)
         OP_QUERY: begin
            w.kind    = KIND_QUERY;
            w.invalid = 1'($urandom);
         end
         OP_FAIL:    w.invalid = 1'b1;
         OP_SYNC:    w.value = sb.sync_reg;
         OP_DISABLE: w.value = sb.disable_reg;
         default: ;
      endcase
      return w;
   endfunction

   task automatic run_directed();
      int i;
      send_word(mk(KIND_QUERY, 32'd0, 1'b0, 10'd0, 1'b0));
      send_word(mk(KIND_TOKEN, 32'd100, 1'b1, 10'd1023, 1'b1));
      send_word(mk(KIND_TOKEN, 32'd100, 1'b0, SYNC_RESET, 1'b0));
      // saturate the failure count, then overflow the lock end
      for (i = 0; i < 9; i++) send_word(mk(KIND_TOKEN, 32'd1000 + i, 1'b1, 10'd0, 1'b0));
      send_word(mk(KIND_TOKEN, 32'hFFFF_FF00, 1'b1, 10'd0, 1'b0));
      send_word(mk(KIND_QUERY, 32'hFFFF_FFFF, 1'b1, 10'd1023, 1'b1));
      send_word(mk(KIND_TOKEN, 32'd500, 1'b0, 10'd0, 1'b1));
      send_word(mk(KIND_TOKEN, 32'd1000, 1'b0, 10'd1023, 1'b1));
      send_word(mk(KIND_TOKEN, 32'd2000, 1'b0, 10'd1, 1'b0));
      send_word(mk(KIND_TOKEN, 32'hFFFF_0000, 1'b0, 10'd5, 1'b0));
      send_word(mk(KIND_TOKEN, 32'hFFFF_FFFF, 1'b0, 10'd1023, 1'b1));
      send_word(mk(KIND_TOKEN, 32'd0, 1'b0, DISABLE_RESET, 1'b1));
      send_word(mk(KIND_QUERY, 32'd0, 1'b0, 10'd0, 1'b0));
      send_word(mk(KIND_TOKEN, 32'd50, 1'b1, 10'd512, 1'b0));
      // tokens still go through while entry is locked
      send_word(mk(KIND_TOKEN, 32'd51, 1'b0, SYNC_RESET, 1'b0));
      send_word(mk(KIND_TOKEN, 32'd52, 1'b0, 10'd2, 1'b1));
      send_word(mk(KIND_QUERY, 32'd52, 1'b0, 10'd0, 1'b0));
   endtask

   task automatic run_random(int count, bit hold_midway);
      int i;
      for (i = 0; i < count; i++) begin
         if (hold_midway && i == count / 2) drain_results();
         send_word(make_random_word());
      end
   endtask

   initial begin
      sb = new();
      burst_left        = 1;
      fail_run          = 0;
      now_cursor        = '0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_kind          = KIND_QUERY;
      req_now_seconds   = '0;
      req_token_invalid = 1'b0;
      req_token_value   = '0;
      req_count_is_odd  = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      configure(32'd0, 32'd1023, 32'd255, 1'b0);
      run_random(WORDS_PER_PHASE, 1'b0);
      configure(32'd1023, 32'd0, 32'd128, 1'b0);
      run_random(WORDS_PER_PHASE, 1'b0);
      // sync equal to disable, divider of zero, write to the unused slot
      configure(32'd500, 32'd500, 32'd0, 1'b1);
      run_random(WORDS_PER_PHASE, 1'b1);
      configure($urandom, $urandom, $urandom, 1'b0);
      run_random(WORDS_PER_PHASE, 1'b0);
      configure(32'(SYNC_RESET), 32'(DISABLE_RESET), 32'(DIVIDER_RESET), 1'b0);
      run_random(WORDS_PER_PHASE, 1'b0);

      drain_results();
      repeat (40) @(negedge clock);
      if (sb.errors == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   // Result side: switch between stall patterns every so often.
   initial begin
      int mode;
      int mode_left;
      int hold;
      int tick;
      mode      = 0;
      mode_left = 0;
      hold      = 0;
      tick      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         tick++;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom);
            2: rsp_ready <= (tick % 4 == 0);
            default: begin
               if (hold > 0) begin
                  hold--;
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
                  hold = $urandom_range(1, 16);
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_status_word({rsp_active, rsp_entry_allowed, rsp_blink_code,
                               rsp_credit_end, rsp_lock_end});
   end

   // Abort when neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

endmodule

// ===== files.f =====
+incdir+src
src/palt_pkg.sv
src/palt_ctrl.sv
src/palt_dp.sv
src/prepaid_activation_lockout_timer_unit.sv
src/palt_checker.sv
tb/tb_top.sv
